// ===== rtl/core/pip_pkg.sv =====
// ============================================================================
// pip_pkg: shared types and constants for the point-in-polygon test
// Function codes, sequencer states and the edge unit request/response types.
// ============================================================================
package pip_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned PROD_W  = 2 * (COORD_W + 1);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_RESP
    } t_state;

    // One edge (a -> b) and the query point, handed to the edge unit.
    typedef struct packed {
        logic                      vld;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
    } t_edge_req;

    typedef struct packed {
        logic busy;    // an edge is in the product stage
        logic toggle;  // that edge flips the inside flag
    } t_edge_rsp;

endpackage

// ===== rtl/core/pip_ram.sv =====
// ============================================================================
// pip_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module pip_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pip_edge.sv =====
// ============================================================================
// pip_edge: shared edge crossing unit
// Straddle check and exact cross-multiplied left-of-edge test, one edge per
// cycle; the products are registered and compared from their registers.
// ============================================================================
module pip_edge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pip_pkg::t_edge_req i_req,
    output pip_pkg::t_edge_rsp o_rsp
);

    localparam int unsigned DW = pip_pkg::COORD_W + 1;

    logic signed [DW-1:0]              dxp;   // px - xb
    logic signed [DW-1:0]              dya;   // ya - yb
    logic signed [DW-1:0]              dxa;   // xa - xb
    logic signed [DW-1:0]              dyp;   // py - yb
    logic                              straddle;

    logic                              r_valid;
    logic                              r_straddle;
    logic                              r_dpos;
    logic signed [pip_pkg::PROD_W-1:0] r_lhs;
    logic signed [pip_pkg::PROD_W-1:0] r_rhs;
    logic                              left;

    always_comb begin
        dxp      = DW'(i_req.px) - DW'(i_req.xb);
        dya      = DW'(i_req.ya) - DW'(i_req.yb);
        dxa      = DW'(i_req.xa) - DW'(i_req.xb);
        dyp      = DW'(i_req.py) - DW'(i_req.yb);
        straddle = (i_req.yb > i_req.py) != (i_req.ya > i_req.py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_straddle <= straddle;
        r_dpos     <= i_req.ya > i_req.yb;
        r_lhs      <= dxp * dya;
        r_rhs      <= dxa * dyp;
    end

    // sign of the divisor decides the direction of the compare
    assign left         = r_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);
    assign o_rsp.busy   = r_valid;
    assign o_rsp.toggle = r_valid & r_straddle & left;

endmodule

// ===== rtl/core/point_in_polygon_test_top.sv =====
// ============================================================================
// point_in_polygon_test_top: even-odd crossing-number point-in-polygon test
// Vertex store, edge-walk sequencer and result register around pip_edge.
// ============================================================================
// Usage:
//   Input stream (s_axis): tuser carries the function code (clear, append
//   vertex, test point); tdata carries coord_x in [15:0], coord_y in [31:16].
//   Output stream (m_axis): one result per request; tdata bit 0 is
//   inside_res, bit 1 is status (1 = vertex dropped, store full).
//   Clear and append: accept, then the response state loads the result.
//   A test point with n > 0 stored vertices reads n+1 vertices from the RAM,
//   one per cycle (last vertex first, then 0..n-1), and each edge passes the
//   shared edge unit (one product stage); the result is loaded once the walk
//   has drained. The single RAM read port and the one edge unit set the pace
//   of the walk.
//   The input is ready only in the idle state; one request is worked at a
//   time. The result sits in an output register; the next request is taken
//   while it waits, and only the load of a further result stalls on it.
//   Reset (synchronous, active low) empties the polygon and drops any
//   pending result. Vertex RAM contents are not cleared; only entries below
//   the vertex count are ever read.
// ============================================================================
module point_in_polygon_test_top #(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // coord_x [15:0], coord_y [31:16]
    input  logic [1:0]  i_s_axis_tuser,   // func [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // inside_res [0], status [1], zero
);

    localparam int unsigned AW = $clog2(MAX_VERTICES);
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned VW = 2 * pip_pkg::COORD_W;

    // sequencer state
    pip_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_rd_vld, n_rd_vld;
    logic            r_rd_first, n_rd_first;
    logic            r_inside, n_inside;
    logic            r_out_valid, n_out_valid;

    // payload registers
    logic signed [pip_pkg::COORD_W-1:0] r_px, n_px;
    logic signed [pip_pkg::COORD_W-1:0] r_py, n_py;
    logic signed [pip_pkg::COORD_W-1:0] r_prev_x, n_prev_x;
    logic signed [pip_pkg::COORD_W-1:0] r_prev_y, n_prev_y;
    logic                               r_res_inside, n_res_inside;
    logic                               r_res_status, n_res_status;
    logic                               r_out_inside, n_out_inside;
    logic                               r_out_status, n_out_status;

    logic                   accept;
    logic [pip_pkg::FUNC_W-1:0] func;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [CW-1:0]          rd_sel;
    logic [VW-1:0]          ram_rdata;
    logic                   out_free;
    pip_pkg::t_edge_req     edge_req;
    pip_pkg::t_edge_rsp     edge_rsp;

    assign o_s_axis_tready = (r_state == pip_pkg::ST_IDLE);
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;
    assign func            = i_s_axis_tuser;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // append writes at the current fill position
    assign ram_we    = accept && (func == pip_pkg::FUNC_APPEND)
                       && (r_count != CW'(MAX_VERTICES));
    assign ram_waddr = r_count[AW-1:0];

    // walk order: last vertex first, then 0 .. n-1
    assign rd_sel    = (r_idx == '0) ? (r_count - CW'(1)) : (r_idx - CW'(1));
    assign ram_raddr = rd_sel[AW-1:0];

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // edge a is the previously read vertex, edge b the one just read
    always_comb begin
        edge_req.vld = r_rd_vld && !r_rd_first;
        edge_req.px  = r_px;
        edge_req.py  = r_py;
        edge_req.xa  = r_prev_x;
        edge_req.ya  = r_prev_y;
        edge_req.xb  = ram_rdata[pip_pkg::COORD_W-1:0];
        edge_req.yb  = ram_rdata[VW-1:pip_pkg::COORD_W];
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (edge_req),
        .o_rsp   (edge_rsp)
    );

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_rd_first   = r_rd_first;
        n_inside     = r_inside ^ edge_rsp.toggle;
        n_px         = r_px;
        n_py         = r_py;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_res_inside = r_res_inside;
        n_res_status = r_res_status;
        n_out_inside = r_out_inside;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;

        if (r_rd_vld) begin
            n_prev_x = ram_rdata[pip_pkg::COORD_W-1:0];
            n_prev_y = ram_rdata[VW-1:pip_pkg::COORD_W];
        end

        case (r_state)
            pip_pkg::ST_IDLE: begin
                if (accept) begin
                    n_res_inside = 1'b0;
                    n_res_status = 1'b0;
                    n_state      = pip_pkg::ST_RESP;
                    case (func)
                        pip_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        pip_pkg::FUNC_APPEND: begin
                            if (r_count != CW'(MAX_VERTICES)) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_res_status = 1'b1;
                            end
                        end
                        pip_pkg::FUNC_QUERY: begin
                            n_px     = i_s_axis_tdata[pip_pkg::COORD_W-1:0];
                            n_py     = i_s_axis_tdata[VW-1:pip_pkg::COORD_W];
                            n_idx    = '0;
                            n_inside = 1'b0;
                            if (r_count != '0) begin
                                n_state = pip_pkg::ST_WALK;
                            end
                        end
                        default: begin
                            // unused code: no state change, zero result
                        end
                    endcase
                end
            end
            pip_pkg::ST_WALK: begin
                n_rd_vld   = 1'b1;
                n_rd_first = (r_idx == '0);
                n_idx      = r_idx + CW'(1);
                if (r_idx == r_count) begin
                    n_state = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN: begin
                // wait for the last read and last edge product to retire
                if (!r_rd_vld && !edge_rsp.busy) begin
                    n_res_inside = r_inside;
                    n_state      = pip_pkg::ST_RESP;
                end
            end
            pip_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_res_inside;
                    n_out_status = r_res_status;
                    n_state      = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pip_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_first  <= 1'b0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_rd_first  <= n_rd_first;
            r_inside    <= n_inside;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_prev_x     <= n_prev_x;
        r_prev_y     <= n_prev_y;
        r_res_inside <= n_res_inside;
        r_res_status <= n_res_status;
        r_out_inside <= n_out_inside;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_status, r_out_inside};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for point_in_polygon_test_top
// Drives clear / append / query / unused-code requests through the input
// stream, predicts every result with an exact crossing-number model, and
// compares each result field by field in arrival order. Both stream sides
// idle at random, except in quiet stretches and at the end of the run.
// ============================================================================
module testbench;

    localparam int unsigned       COORD_W     = pip_pkg::COORD_W;
    localparam int unsigned       FUNC_W      = pip_pkg::FUNC_W;
    localparam int unsigned       MAX_VERTS   = 64;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                N_REQUESTS  = 1250;
    localparam int                QUIET_FROM  = 1100;   // no idling after this
    localparam int                DRAIN_WAIT  = 80;     // > worst query latency
    localparam int                MAX_PRINTS  = 40;

    // ------------------------------------------------------------------------
    // Expected result of one request
    // ------------------------------------------------------------------------
    typedef struct {
        logic inside_res;
        logic status;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the polygon, predicts verdicts and checks them
    // ------------------------------------------------------------------------
    class polygon_scoreboard;
        logic signed [COORD_W-1:0] vert_x [MAX_VERTS];
        logic signed [COORD_W-1:0] vert_y [MAX_VERTS];
        int unsigned               vert_count;
        t_verdict                  pending_verdicts [$];
        int                        mismatches;

        function new();
            vert_count = 0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return pending_verdicts.size();
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < MAX_PRINTS)
                $display("%0t ns: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Even-odd walk: edge (last, 0), then (0,1), (1,2), ...
        // The x-intersection test is cross-multiplied, sign of dy decides.
        function logic crossing_parity(input longint px, input longint py);
            longint      xa, ya, xb, yb, dy, lhs, rhs;
            int unsigned a;
            logic        parity;
            logic        left;
            parity = 1'b0;
            if (vert_count == 0)
                return 1'b0;
            a = vert_count - 1;
            for (int unsigned b = 0; b < vert_count; b++) begin
                xa = vert_x[a];
                ya = vert_y[a];
                xb = vert_x[b];
                yb = vert_y[b];
                if ((yb > py) != (ya > py)) begin
                    dy   = ya - yb;
                    lhs  = (px - xb) * dy;
                    rhs  = (xa - xb) * (py - yb);
                    left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                    if (left)
                        parity = !parity;
                end
                a = b;
            end
            return parity;
        endfunction

        function void note_request(input logic [FUNC_W-1:0] func,
                                   input logic signed [COORD_W-1:0] cx,
                                   input logic signed [COORD_W-1:0] cy);
            t_verdict v;
            v.inside_res = 1'b0;
            v.status     = 1'b0;
            case (func)
                pip_pkg::FUNC_CLEAR: begin
                    vert_count = 0;
                end
                pip_pkg::FUNC_APPEND: begin
                    if (vert_count < MAX_VERTS) begin
                        vert_x[vert_count] = cx;
                        vert_y[vert_count] = cy;
                        vert_count++;
                    end else begin
                        v.status = 1'b1;    // store full, vertex dropped
                    end
                end
                pip_pkg::FUNC_QUERY: begin
                    v.inside_res = crossing_parity(cx, cy);
                end
                default: ;                  // unused code: no state change
            endcase
            pending_verdicts.push_back(v);
        endfunction

        task check_result(input logic [7:0] tdata);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with none expected", tdata));
            end else begin
                v = pending_verdicts.pop_front();
                if (tdata[0] !== v.inside_res)
                    report_mismatch($sformatf("inside_res %b, predicted %b",
                                              tdata[0], v.inside_res));
                if (tdata[1] !== v.status)
                    report_mismatch($sformatf("status %b, predicted %b",
                                              tdata[1], v.status));
                if (tdata[7:2] !== 6'd0)
                    report_mismatch($sformatf("pad bits 0x%02h not zero", tdata[7:2]));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // coord_x [15:0], coord_y [31:16]
    logic [1:0]  i_s_axis_tuser  = '0;   // func [1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [7:0]  o_m_axis_tdata;         // inside_res [0], status [1], zero

    polygon_scoreboard sb = new();

    int requests_sent = 0;   // unused-code requests not counted
    bit calm          = 1'b0; // no idling on either side while set
    bit quiet         = 1'b0; // closing stretch: calm for good
    int rx_stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_in_polygon_test_top #(
        .MAX_VERTICES (MAX_VERTS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Monitor: both handshakes seen with pre-edge values.
    // Results are checked before a same-edge request is noted; a request's
    // result never lands on its own accept edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                i_s_axis_tdata[31:16]);
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: random stalls, started only when not calm
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left   <= rx_stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left   <= $urandom_range(0, 2);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: optional idle burst, then hold until accepted.
    // tvalid gets a single assignment per step, so back-to-back requests
    // keep it high.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [COORD_W-1:0] cx,
                                input logic [COORD_W-1:0] cy);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {cy, cx};
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (func != FUNC_UNUSED)
            requests_sent++;
    endtask

    // span 0: full 16-bit range; otherwise uniform in [-span, span]
    function automatic logic [COORD_W-1:0] pick_coord(input int span);
        if (span == 0)
            return COORD_W'($urandom_range(0, 65535));
        return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // ------------------------------------------------------------------------
    // One polygon: (usually) clear, append vertices, then query points
    // aimed at vertices, edge midpoints and random spots.
    // ------------------------------------------------------------------------
    task automatic run_polygon_sequence();
        int                span;
        int                n_vert;
        int                n_query;
        int                sel;
        int                i;
        int                j;
        int                roll;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] vx [$];
        logic signed [COORD_W-1:0] vy [$];
        calm = quiet || ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 8;      // dense grid: many hits on edges and vertices
            2:       span = 200;
            default: span = 4000;
        endcase
        roll = $urandom_range(0, 19);
        if (roll == 0)
            n_vert = $urandom_range(60, 68);   // can fill the store and overflow
        else if (roll < 3)
            n_vert = $urandom_range(0, 2);
        else
            n_vert = $urandom_range(3, 12);
        if ($urandom_range(0, 7) != 0)
            send_request(pip_pkg::FUNC_CLEAR, pick_coord(0), pick_coord(0));
        for (int k = 0; k < n_vert; k++) begin
            x = pick_coord(span);
            y = pick_coord(span);
            vx.push_back(x);
            vy.push_back(y);
            send_request(pip_pkg::FUNC_APPEND, x, y);
        end
        n_query = $urandom_range(2, 8);
        for (int k = 0; k < n_query; k++) begin
            sel = (vx.size() == 0) ? 0 : $urandom_range(0, 4);
            i   = (vx.size() == 0) ? 0 : $urandom_range(0, vx.size() - 1);
            j   = (vx.size() == 0) ? 0 : (i + 1) % vx.size();
            case (sel)
                1: begin
                    x = vx[i];
                    y = vy[i];
                end
                2: begin
                    x = COORD_W'((int'(vx[i]) + int'(vx[j])) / 2);
                    y = COORD_W'((int'(vy[i]) + int'(vy[j])) / 2);
                end
                3: begin
                    x = pick_coord(span);
                    y = vy[i];              // level with a vertex
                end
                default: begin
                    x = pick_coord(span);
                    y = pick_coord(span);
                end
            endcase
            send_request(pip_pkg::FUNC_QUERY, x, y);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty, single vertex, two vertices, extreme triangle,
        // points on a vertex and on an edge, unused code, query after clear.
        send_request(pip_pkg::FUNC_CLEAR,  16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_APPEND, 16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_QUERY,  16'hFFFF, 16'hFFFF);
        send_request(pip_pkg::FUNC_APPEND, 16'h0000, 16'h0010);
        send_request(pip_pkg::FUNC_QUERY,  16'hFFFF, 16'h0008);
        send_request(pip_pkg::FUNC_CLEAR,  16'hFFFF, 16'hFFFF);
        send_request(pip_pkg::FUNC_APPEND, 16'h8000, 16'h8000);
        send_request(pip_pkg::FUNC_APPEND, 16'h7FFF, 16'h8000);
        send_request(pip_pkg::FUNC_APPEND, 16'h0000, 16'h7FFF);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_QUERY,  16'h8000, 16'h7FFF);
        send_request(pip_pkg::FUNC_QUERY,  16'h7FFF, 16'h7FFF);
        send_request(pip_pkg::FUNC_QUERY,  16'h8000, 16'h8000);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h8000);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h7FFE);
        send_request(pip_pkg::FUNC_QUERY,  16'hC000, 16'h0000);
        send_request(FUNC_UNUSED,          16'hFFFF, 16'hFFFF);
        send_request(pip_pkg::FUNC_QUERY,  16'h0001, 16'h0001);
        send_request(pip_pkg::FUNC_CLEAR,  16'h0000, 16'h0000);
        send_request(pip_pkg::FUNC_QUERY,  16'h0000, 16'h0000);

        // Random: mostly well-formed polygons, some single-request noise
        while (requests_sent < N_REQUESTS) begin
            if (requests_sent >= QUIET_FROM) begin
                quiet = 1'b1;
                calm  = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                calm = quiet || ($urandom_range(0, 3) == 0);
                send_request(FUNC_W'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
            end else begin
                run_polygon_sequence();
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("point_in_polygon_test_top regression: pass");
        else
            $display("point_in_polygon_test_top regression: fail");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("point_in_polygon_test_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test_top.sv
tb/sv/testbench.sv
